// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the combination enumerator RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KCE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/kce_pkg.sv -----
// Package for the combination enumerator: widths, register codes, types.
// No dependencies.
package kce_pkg;

    localparam int ELEM_W      = 5;
    localparam int POS_W       = 4;
    localparam int CMP_W       = ELEM_W + 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;
    localparam int MAX_SET_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHOOSE   = 2'd1;

    localparam logic [ELEM_W-1:0] SET_SIZE_RST = 5'd4;
    localparam logic [ELEM_W-1:0] CHOOSE_RST   = 5'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_SINGLE
    } state_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic load_first;
        logic capture;
        logic shift;
    } cell_ctrl_t;

    // What one cell holds and hands to its left neighbor.
    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              pivot;
        logic              follow;
    } cell_data_t;

endpackage

// ----- rtl/core/k_combination_enumerator_top.sv -----
// Top level of the k-combination enumerator: chain of element cells plus sequencer.
// Depends on kce_pkg, kce_cell and kce_ctrl.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes n (index 0)
//   and k (index 1); ready only while idle, and a pending write holds s_tready
//   low. A write to n or k drops the running enumeration; restart afterwards.
//   Input stream s_*: one beat per request, s_tdata[0] = restart.
//   Output stream m_*: k beats per combination, element and position in
//   m_tdata, tlast on the final beat, tuser flags for empty / exhausted.
//   Special cases (k = 0, k > n, advance before start or past the end) give
//   one beat with element and position zero.
// Sequence:
//   An accepted request enters the emit state (or the single-beat state) and
//   each beat is then registered in the output register. The row of cells
//   rotates one step per emitted element, and the successor is formed as the
//   elements stream out of the head cell.
// Reset clears n to 4, k to 2, the cell row and the enumeration flags.
// A stalled receiver holds the output register; the row stops rotating until
// the beat is taken, and s_tready stays low until the last beat is issued.
module k_combination_enumerator_top #(
    parameter int MAX_SET = kce_pkg::MAX_SET_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kce_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kce_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] restart, rest zero
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kce_pkg::M_TDATA_W-1:0]   m_tdata,   // [4:0] element, [8:5] position
    output logic                            m_tlast,   // last_of_combination
    output logic [kce_pkg::M_TUSER_W-1:0]   m_tuser    // [0] is_empty, [1] exhausted
);
    import kce_pkg::*;

    localparam int PAD_W = M_TDATA_W - ELEM_W - POS_W;

    cell_ctrl_t        cell_ctrl;
    cell_data_t        cell_q [MAX_SET];
    logic              cell_at_max [MAX_SET];
    logic [ELEM_W-1:0] feedback;
    logic [ELEM_W-1:0] n_eff;
    logic [ELEM_W-1:0] k;
    logic [ELEM_W-1:0] m_element;
    logic [POS_W-1:0]  m_position;
    logic              m_empty;
    logic              m_exhausted;

    // row of cells; each shifts toward cell 0, the head that feeds the output
    for (genvar i = 0; i < MAX_SET; i++)
    begin : g_cell
        cell_data_t nb;
        logic       nb_at_max;

        if (i == MAX_SET - 1)
        begin : g_end
            assign nb        = '0;
            assign nb_at_max = 1'b0;
        end
        else
        begin : g_mid
            assign nb        = cell_q[i + 1];
            assign nb_at_max = cell_at_max[i + 1];
        end

        kce_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .n_eff     (n_eff),
            .k         (k),
            .nb        (nb),
            .nb_at_max (nb_at_max),
            .feedback  (feedback),
            .q         (cell_q[i]),
            .at_max    (cell_at_max[i])
        );
    end

    kce_ctrl #(
        .MAX_SET (MAX_SET)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .restart      (s_tdata[0]),
        .s_tready     (s_tready),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg_ready    (cfg_ready),
        .front        (cell_q[0]),
        .front_at_max (cell_at_max[0]),
        .cell_ctrl    (cell_ctrl),
        .feedback     (feedback),
        .n_eff        (n_eff),
        .k            (k),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_element    (m_element),
        .m_position   (m_position),
        .m_last       (m_tlast),
        .m_empty      (m_empty),
        .m_exhausted  (m_exhausted)
    );

    assign m_tdata = {{PAD_W{1'b0}}, m_position, m_element};
    assign m_tuser = {m_exhausted, m_empty};

endmodule

// ----- rtl/core/kce_cell.sv -----
// One element cell of the combination chain.
// Depends on kce_pkg.
module kce_cell #(
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  kce_pkg::cell_ctrl_t        ctrl,
    input  logic [kce_pkg::ELEM_W-1:0] n_eff,
    input  logic [kce_pkg::ELEM_W-1:0] k,
    input  kce_pkg::cell_data_t        nb,
    input  logic                       nb_at_max,
    input  logic [kce_pkg::ELEM_W-1:0] feedback,
    output kce_pkg::cell_data_t        q,
    output logic                       at_max
);
    import kce_pkg::*;

    cell_data_t       cell_reg;
    cell_data_t       cell_next;
    logic             tail;
    logic [CMP_W-1:0] ceiling;

    // this cell holds the last element of the combination
    assign tail    = (ELEM_W + 1)'(k) == (ELEM_W + 1)'(IDX + 1);
    // largest value allowed at this position: n - k + IDX + 1
    assign ceiling = CMP_W'(n_eff) - CMP_W'(k) + CMP_W'(IDX + 1);
    assign at_max  = CMP_W'(cell_reg.value) == ceiling;
    assign q       = cell_reg;

    always_comb
    begin
        cell_next = cell_reg;
        priority if (ctrl.load_first)
        begin
            cell_next.value  = ELEM_W'(IDX + 1);
            cell_next.pivot  = 1'b0;
            cell_next.follow = 1'b0;
        end
        else if (ctrl.capture)
        begin
            // at_max is monotone along the row, so the pivot is local
            cell_next.pivot  = !at_max && (tail || nb_at_max);
            cell_next.follow = at_max;
        end
        else if (ctrl.shift)
        begin
            if (tail)
            begin
                cell_next.value  = feedback;
                cell_next.pivot  = 1'b0;
                cell_next.follow = 1'b0;
            end
            else
            begin
                cell_next = nb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

endmodule

// ----- rtl/core/kce_ctrl.sv -----
// Sequencer, config registers and output register of the enumerator.
// Depends on kce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kce_ctrl #(
    parameter int MAX_SET = kce_pkg::MAX_SET_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            restart,
    output logic                            s_tready,
    input  logic                            cfg_valid,
    input  logic [kce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kce_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            cfg_ready,
    input  kce_pkg::cell_data_t             front,
    input  logic                            front_at_max,
    output kce_pkg::cell_ctrl_t             cell_ctrl,
    output logic [kce_pkg::ELEM_W-1:0]      feedback,
    output logic [kce_pkg::ELEM_W-1:0]      n_eff,
    output logic [kce_pkg::ELEM_W-1:0]      k,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kce_pkg::ELEM_W-1:0]      m_element,
    output logic [kce_pkg::POS_W-1:0]       m_position,
    output logic                            m_last,
    output logic                            m_empty,
    output logic                            m_exhausted
);
    import kce_pkg::*;

    localparam int CNT_W = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;

    state_t             state_reg, state_next;
    logic [ELEM_W-1:0]  set_size_reg, set_size_next;
    logic [ELEM_W-1:0]  choose_reg, choose_next;
    logic               started_reg, started_next;
    logic               finished_reg, finished_next;
    logic               single_exh_reg, single_exh_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ELEM_W-1:0]  prev_reg, prev_next;
    logic               out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0]  out_elem_reg, out_elem_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;
    logic               out_exh_reg, out_exh_next;

    logic               in_accept;
    logic               step;
    logic               emit_last;
    logic               k_zero;
    logic               k_over;
    logic               can_advance;
    logic [ELEM_W-1:0]  upd;

    logic               last_step;
    logic               count_ok;
    logic               late_adv;
    logic               exh_pending;

    assign n_eff = ((ELEM_W + 1)'(set_size_reg) > (ELEM_W + 1)'(MAX_SET))
                   ? ELEM_W'(MAX_SET) : set_size_reg;
    assign k         = choose_reg;
    assign k_zero    = (choose_reg == '0);
    assign k_over    = (choose_reg > n_eff);
    // a pending register write takes the idle slot before a request
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign step      = (state_reg != ST_IDLE) && (!out_valid_reg || m_tready);
    assign emit_last = ((ELEM_W + 1)'(count_reg) + (ELEM_W + 1)'(1))
                       == (ELEM_W + 1)'(choose_reg);
    assign can_advance = started_reg && !finished_reg && !k_zero && !k_over
                         && !front_at_max;

    // updated value of the element at the head of the row
    always_comb
    begin
        priority if (front.pivot)
        begin
            upd = front.value + ELEM_W'(1);
        end
        else if (front.follow)
        begin
            upd = prev_reg + ELEM_W'(1);
        end
        else
        begin
            upd = front.value;
        end
    end

    assign feedback = upd;

    // next state
    always_comb
    begin
        state_next      = state_reg;
        set_size_next   = set_size_reg;
        choose_next     = choose_reg;
        started_next    = started_reg;
        finished_next   = finished_reg;
        single_exh_next = single_exh_reg;
        count_next      = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                count_next = '0;
                if (in_accept)
                begin
                    if (restart)
                    begin
                        started_next  = 1'b1;
                        finished_next = k_zero || k_over;
                        if (k_zero || k_over)
                        begin
                            state_next      = ST_SINGLE;
                            single_exh_next = !k_zero;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else if (can_advance)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next      = ST_SINGLE;
                        single_exh_next = 1'b1;
                        if (started_reg)
                        begin
                            finished_next = 1'b1;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (step)
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                        count_next = '0;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // writes to n or k drop the enumeration; a restart request is then needed
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SET_SIZE:
                begin
                    set_size_next = cfg_data;
                    started_next  = 1'b0;
                    finished_next = 1'b0;
                end
                REG_CHOOSE:
                begin
                    choose_next   = cfg_data;
                    started_next  = 1'b0;
                    finished_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // cell commands and output register
    always_comb
    begin
        cell_ctrl.load_first = in_accept && restart && !k_zero && !k_over;
        cell_ctrl.capture    = in_accept && !restart && can_advance;
        cell_ctrl.shift      = step && (state_reg == ST_EMIT);

        prev_next      = cell_ctrl.shift ? upd : prev_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_elem_next  = out_elem_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_exh_next   = out_exh_reg;

        if (step)
        begin
            out_valid_next = 1'b1;
            if (state_reg == ST_EMIT)
            begin
                out_elem_next  = upd;
                out_pos_next   = POS_W'(count_reg);
                out_last_next  = emit_last;
                out_empty_next = 1'b0;
                out_exh_next   = 1'b0;
            end
            else
            begin
                out_elem_next  = '0;
                out_pos_next   = '0;
                out_last_next  = 1'b1;
                out_empty_next = !single_exh_reg;
                out_exh_next   = single_exh_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            set_size_reg   <= SET_SIZE_RST;
            choose_reg     <= CHOOSE_RST;
            started_reg    <= 1'b0;
            finished_reg   <= 1'b0;
            single_exh_reg <= 1'b0;
            count_reg      <= '0;
            prev_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_elem_reg   <= '0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b0;
            out_empty_reg  <= 1'b0;
            out_exh_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            set_size_reg   <= set_size_next;
            choose_reg     <= choose_next;
            started_reg    <= started_next;
            finished_reg   <= finished_next;
            single_exh_reg <= single_exh_next;
            count_reg      <= count_next;
            prev_reg       <= prev_next;
            out_valid_reg  <= out_valid_next;
            out_elem_reg   <= out_elem_next;
            out_pos_reg    <= out_pos_next;
            out_last_reg   <= out_last_next;
            out_empty_reg  <= out_empty_next;
            out_exh_reg    <= out_exh_next;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign m_element   = out_elem_reg;
    assign m_position  = out_pos_reg;
    assign m_last      = out_last_reg;
    assign m_empty     = out_empty_reg;
    assign m_exhausted = out_exh_reg;

    assign last_step   = (state_reg == ST_EMIT) && step && emit_last;
    assign count_ok    = (ELEM_W + 1)'(count_reg) < (ELEM_W + 1)'(choose_reg);
    assign late_adv    = in_accept && !restart && finished_reg;
    assign exh_pending = (state_reg == ST_SINGLE) && single_exh_reg;

    `KCE_ASSERT_NEXT(a_emit_ends, last_step, state_reg == ST_IDLE, "emit overran last element")
    `KCE_ASSERT_IMPL(a_count_in_range, state_reg == ST_EMIT, count_ok, "position ran past k")
    `KCE_ASSERT_IMPL(a_elem_nonzero, cell_ctrl.shift, upd != '0, "emitted element is zero")
    `KCE_ASSERT_NEXT(a_done_exhausts, late_adv, exh_pending, "late advance not exhausted")

endmodule
